FILE: hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared constants, codes and control structures of the scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 8;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FUNC_W      = 3;
    localparam int TID_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD         = 3'd0,
        FUNC_REMOVE      = 3'd1,
        FUNC_BLOCK       = 3'd2,
        FUNC_UNBLOCK     = 3'd3,
        FUNC_SCHED       = 3'd4,
        FUNC_SCHED_FIRST = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef logic [ID_W-1:0] id_t;

    typedef struct packed {
        logic cmp_en;
        id_t  cmp_id;
        id_t  wr_data;
    } cell_ctrl_t;

    typedef struct packed {
        logic cmp_en;
        id_t  cmp_id;
        logic pop;
        logic push;
        id_t  push_id;
    } queue_cmd_t;

    typedef struct packed {
        id_t               head;
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] fill_next;
        logic              push_fail;
    } queue_stat_t;

endpackage

FILE: hdl/rrts_req_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel that carries one scheduler operation.
// ----------------------------------------------------------------------------
interface rrts_req_if;
    import rrts_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [TID_W-1:0]   thread_id;

    modport source (output valid, output func, output thread_id, input ready);
    modport sink (input valid, input func, input thread_id, output ready);
endinterface

FILE: hdl/rrts_rsp_if.sv
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel that carries the result of one operation.
// ----------------------------------------------------------------------------
interface rrts_rsp_if;
    import rrts_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                running_valid;
    logic [TID_W-1:0]    running_id;
    logic [COUNT_W-1:0]  ready_count;

    modport source (output valid, output status, output running_valid,
                    output running_id, output ready_count, input ready);
    modport sink (input valid, input status, input running_valid,
                  input running_id, input ready_count, output ready);
endinterface

FILE: hdl/rrts_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one thread id, compares it and shifts in from its right neighbor.
// ----------------------------------------------------------------------------
module rrts_cell (
    input  logic                clk,
    input  rrts_pkg::cell_ctrl_t ctrl,
    input  rrts_pkg::id_t       right,
    input  logic                valid,
    input  logic                shift_in,
    input  logic                wr,
    output rrts_pkg::id_t       entry,
    output logic                shift_out
);
    import rrts_pkg::*;

    id_t  entry_reg;
    id_t  entry_next;
    logic hit;

    assign hit       = ctrl.cmp_en && valid && (entry_reg == ctrl.cmp_id);
    assign shift_out = shift_in || hit;
    assign entry     = entry_reg;

    always_comb
    begin
        if (wr)
        begin
            entry_next = ctrl.wr_data;
        end
        else if (shift_out)
        begin
            entry_next = right;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hdl/rrts_queue.sv
// ----------------------------------------------------------------------------
// Thread queue
// Row of cells with a fill counter: delete first match, pop head, push tail.
// ----------------------------------------------------------------------------
module rrts_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrts_pkg::queue_cmd_t  cmd,
    output rrts_pkg::queue_stat_t stat
);
    import rrts_pkg::*;

    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W-1:0]    fill_after;
    logic                 found;
    logic                 push_ok;
    cell_ctrl_t           cell_ctrl;
    id_t                  entries [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] shift_chain;
    logic [QUEUE_DEPTH-1:0] valid;
    logic [QUEUE_DEPTH-1:0] wr_sel;

    assign cell_ctrl.cmp_en  = cmd.cmp_en;
    assign cell_ctrl.cmp_id  = cmd.cmp_id;
    assign cell_ctrl.wr_data = cmd.push_id;

    assign shift_chain[0] = cmd.pop;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            id_t right;
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = entries[gi+1];
            end

            rrts_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .right     (right),
                .valid     (valid[gi]),
                .shift_in  (shift_chain[gi]),
                .wr        (wr_sel[gi]),
                .entry     (entries[gi]),
                .shift_out (shift_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            valid[i] = fill_reg > FILL_W'(i);
        end
        found      = cmd.pop ? (fill_reg != '0) : shift_chain[QUEUE_DEPTH];
        fill_after = fill_reg - FILL_W'(found);
        push_ok    = cmd.push && (fill_after < FILL_W'(QUEUE_DEPTH));
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            wr_sel[i] = push_ok && (fill_after == FILL_W'(i));
        end
        fill_next  = fill_after + FILL_W'(push_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign stat.head      = entries[0];
    assign stat.fill      = fill_reg;
    assign stat.fill_next = fill_next;
    assign stat.push_fail = cmd.push && !push_ok;

endmodule

FILE: hdl/round_robin_thread_scheduler_top.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Ready queue, blocked list and running thread, one operation per request.
// The response is registered and appears in the cycle after acceptance.
// Throughput: one request per cycle while the response is taken; each cell compares and shifts in parallel.
// Reset clears both fill counters and the running thread; entries are unset.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    rrts_req_if.sink    req,
    rrts_rsp_if.source  rsp
);
    import rrts_pkg::*;

    logic        accept;
    id_t         id;
    func_t       func;
    queue_cmd_t  rdy_cmd;
    queue_cmd_t  blk_cmd;
    queue_stat_t rdy_stat;
    queue_stat_t blk_stat;
    status_t     status;

    logic        run_flag_reg;
    logic        run_flag_next;
    id_t         run_id_reg;
    id_t         run_id_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_run_valid_reg;
    logic [TID_W-1:0]    out_run_id_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign id        = id_t'(req.thread_id);
    assign func      = func_t'(req.func);

    rrts_queue u_ready (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rdy_cmd),
        .stat  (rdy_stat)
    );

    rrts_queue u_blocked (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (blk_cmd),
        .stat  (blk_stat)
    );

    always_comb
    begin
        rdy_cmd       = '0;
        blk_cmd       = '0;
        rdy_cmd.cmp_id  = id;
        blk_cmd.cmp_id  = id;
        rdy_cmd.push_id = id;
        blk_cmd.push_id = id;
        status        = STATUS_OK;
        run_flag_next = run_flag_reg;
        run_id_next   = run_id_reg;
        if (accept)
        begin
            unique case (func)
                FUNC_ADD:
                begin
                    rdy_cmd.push = 1'b1;
                    if (rdy_stat.push_fail)
                    begin
                        status = STATUS_FULL;
                    end
                end
                FUNC_REMOVE:
                begin
                    rdy_cmd.cmp_en = 1'b1;
                    blk_cmd.cmp_en = 1'b1;
                    if (run_flag_reg && run_id_reg == id)
                    begin
                        run_flag_next = 1'b0;
                        run_id_next   = '0;
                    end
                end
                FUNC_BLOCK:
                begin
                    rdy_cmd.cmp_en = 1'b1;
                    blk_cmd.push   = 1'b1;
                    if (run_flag_reg && run_id_reg == id)
                    begin
                        run_flag_next = 1'b0;
                        run_id_next   = '0;
                    end
                    if (blk_stat.push_fail)
                    begin
                        status = STATUS_FULL;
                    end
                end
                FUNC_UNBLOCK:
                begin
                    blk_cmd.cmp_en = 1'b1;
                    rdy_cmd.push   = 1'b1;
                    if (rdy_stat.push_fail)
                    begin
                        status = STATUS_FULL;
                    end
                end
                FUNC_SCHED:
                begin
                    if (run_flag_reg)
                    begin
                        if (rdy_stat.fill == FILL_W'(QUEUE_DEPTH))
                        begin
                            status = STATUS_FULL;
                        end
                        else if (rdy_stat.fill != '0)
                        begin
                            rdy_cmd.pop     = 1'b1;
                            rdy_cmd.push    = 1'b1;
                            rdy_cmd.push_id = run_id_reg;
                            run_id_next     = rdy_stat.head;
                        end
                    end
                    else if (rdy_stat.fill == '0)
                    begin
                        status        = STATUS_EMPTY;
                        run_flag_next = 1'b0;
                        run_id_next   = '0;
                    end
                    else
                    begin
                        rdy_cmd.pop   = 1'b1;
                        run_flag_next = 1'b1;
                        run_id_next   = rdy_stat.head;
                    end
                end
                FUNC_SCHED_FIRST:
                begin
                    if (rdy_stat.fill == '0)
                    begin
                        status        = STATUS_EMPTY;
                        run_flag_next = 1'b0;
                        run_id_next   = '0;
                    end
                    else
                    begin
                        rdy_cmd.pop   = 1'b1;
                        run_flag_next = 1'b1;
                        run_id_next   = rdy_stat.head;
                    end
                end
                default:
                begin
                    status = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_flag_reg  <= 1'b0;
            run_id_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_flag_reg <= run_flag_next;
            run_id_reg   <= run_id_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg    <= status;
            out_run_valid_reg <= run_flag_next;
            out_run_id_reg    <= run_flag_next ? TID_W'(run_id_next) : '0;
            out_count_reg     <= COUNT_W'(rdy_stat.fill_next);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.running_valid = out_run_valid_reg;
    assign rsp.running_id    = out_run_id_reg;
    assign rsp.ready_count   = out_count_reg;

endmodule
